// File: rtl/pmjc_pkg.sv
// Package with the constants, codes and types of the pairwise match distance block.
package pmjc_pkg;

  localparam int MAX_SEQS = 64;
  localparam int SEQ_W    = $clog2(MAX_SEQS);
  localparam int PAIR_W   = 2 * SEQ_W;
  localparam int PAIRS    = MAX_SEQS * MAX_SEQS;
  localparam int CNT_W    = 40;
  localparam int LEN_W    = 32;
  localparam int SUM_W    = LEN_W + 1;
  localparam int DIST_W   = 23;
  localparam int LIN_W    = 44;
  localparam int EXP_W    = 6;
  localparam int FRAC_W   = 24;
  localparam int LOG_W    = EXP_W + FRAC_W;
  localparam int MAN_W    = 31;
  localparam int PROD_W   = 2 * MAN_W;
  localparam int IDX_W    = 5;

  localparam logic [MAN_W-1:0]  LN_SCALE = MAN_W'(8721810);
  localparam logic [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_LEN   = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_NOSHARED = 2'd1,
    ST_LOWP     = 2'd2,
    ST_SAME     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ADD_RD, S_ADD_WR, S_LEN_WR, S_Q_RD, S_Q_RD2, S_Q_EVAL,
    S_LOG_X, S_LOG_Y, S_SCALE_MUL, S_SCALE_END, S_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    L_IDLE, L_NORM, L_SQ, L_TAKE
  } log_state_e;

  typedef struct packed {
    logic             start;
    logic [LIN_W-1:0] value;
  } log_req_t;

  typedef struct packed {
    logic             done;
    logic [LOG_W-1:0] result;
  } log_rsp_t;

endpackage

// File: rtl/pmjc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pmjc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: rtl/pmjc_mul.sv
// Shared unsigned multiplier with a registered product.
module pmjc_mul (
  input  logic                        clk_i,
  input  logic [pmjc_pkg::MAN_W-1:0]  a_i,
  input  logic [pmjc_pkg::MAN_W-1:0]  b_i,
  output logic [pmjc_pkg::PROD_W-1:0] p_o
);
  import pmjc_pkg::*;

  logic [PROD_W-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= PROD_W'(a_i) * PROD_W'(b_i);
  end

  assign p_o = p_q;
endmodule

// File: rtl/pmjc_log2.sv
// Iterative base-two logarithm in Q.24: bit-serial normalisation, then repeated squaring.
module pmjc_log2 (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pmjc_pkg::log_req_t          req_i,
  output pmjc_pkg::log_rsp_t          rsp_o,
  output logic [pmjc_pkg::MAN_W-1:0]  mul_a_o,
  input  logic [pmjc_pkg::PROD_W-1:0] mul_p_i
);
  import pmjc_pkg::*;

  log_state_e        state_q, state_d;
  logic [LIN_W-1:0]  x_q, x_d;
  logic [EXP_W-1:0]  e_q, e_d;
  logic [MAN_W-1:0]  m_q, m_d;
  logic [FRAC_W-1:0] frac_q, frac_d;
  logic [IDX_W-1:0]  i_q, i_d;
  logic              done_q, done_d;
  logic [MAN_W:0]    sq;

  assign sq = mul_p_i[PROD_W-1:MAN_W-1];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE:  if (req_i.start) state_d = L_NORM;
      L_NORM:  if (x_q[LIN_W-1]) state_d = L_SQ;
      L_SQ:    state_d = L_TAKE;
      L_TAKE:  state_d = (i_q == '0) ? L_IDLE : L_SQ;
      default: state_d = L_IDLE;
    endcase
  end

  always_comb begin
    x_d    = x_q;
    e_d    = e_q;
    m_d    = m_q;
    frac_d = frac_q;
    i_d    = i_q;
    done_d = 1'b0;
    unique case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          x_d    = req_i.value;
          e_d    = EXP_W'(LIN_W - 1);
          frac_d = '0;
        end
      end
      L_NORM: begin
        if (x_q[LIN_W-1]) begin
          m_d = x_q[LIN_W-1 -: MAN_W];
          i_d = IDX_W'(FRAC_W - 1);
        end else begin
          x_d = {x_q[LIN_W-2:0], 1'b0};
          e_d = e_q - 1'b1;
        end
      end
      L_SQ: begin
      end
      L_TAKE: begin
        if (sq[MAN_W]) begin
          m_d        = sq[MAN_W:1];
          frac_d[i_q] = 1'b1;
        end else begin
          m_d = sq[MAN_W-1:0];
        end
        i_d = i_q - 1'b1;
        if (i_q == '0) done_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    e_q    <= e_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    i_q    <= i_d;
  end

  assign mul_a_o       = m_q;
  assign rsp_o.done    = done_q;
  assign rsp_o.result  = {e_q, frac_q};
endmodule

// File: rtl/pairwise_match_jukes_cantor.sv
// Top level of the pairwise shared-match counter with Jukes-Cantor distance.
// Items enter on the s_axis beat channel: tuser carries the operation, tdata the two
// sequence indices, the match flag and the amount. A matching add beat on distinct
// indices adds its amount to the pair count (saturating at 40 bits); a length beat
// stores one sequence length; a query beat yields one result beat on m_axis with the
// status in tuser and the distance and shared count in tdata. Other beats give no result.
// After reset the block clears all 4096 entries of the count memory, one entry a
// cycle, and s_axis_tready_o stays low meanwhile.
// An add is a read-modify-write on the count memory. A query that needs a logarithm
// runs two of them, each a bit-serial normalisation and 24 squarings on the shared
// multiplier, followed by one scaling multiply on the same unit.
// One item is in work at a time; s_axis_tready_o is high only when idle. A result
// beat holds on m_axis until it is taken, and no new item is taken while it waits.
module pairwise_match_jukes_cantor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // first_seq[5:0], second_seq[11:6], op_is_match[12], amount[44:13], zero[47:45]
  input  logic [47:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // distance[22:0], shared_count[62:23], zero[63]
  output logic [63:0] m_axis_tdata_o,
  // status[1:0]
  output logic [1:0]  m_axis_tuser_o
);
  import pmjc_pkg::*;

  top_state_e        state_q, state_d;
  logic [PAIR_W:0]   clr_q, clr_d;
  logic [SEQ_W-1:0]  a_q, b_q, lo, hi;
  logic              match_q;
  logic [LEN_W-1:0]  amt_q, len_lo_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [SUM_W-1:0]  lsum_q, lsum;
  logic [LOG_W-1:0]  lx_q;
  logic [MAN_W-1:0]  mag_q;
  logic              pos_q;
  status_e           status_q;
  logic [DIST_W-1:0] dist_q;

  logic              cnt_we;
  logic [PAIR_W-1:0] cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
  logic              len_we;
  logic [SEQ_W-1:0]  len_raddr;
  logic [LEN_W-1:0]  len_rdata;
  logic [CNT_W:0]    add_sum;
  logic [LIN_W-1:0]  s8, x1, x2;
  logic              low_p;
  log_req_t          log_req;
  log_rsp_t          log_rsp;
  logic [MAN_W-1:0]  log_mul_a, mul_a, mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [PROD_W:0]   rnd;
  logic [MAN_W-1:0]  r;
  logic              in_acc;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign lo     = (a_q < b_q) ? a_q : b_q;
  assign hi     = (a_q < b_q) ? b_q : a_q;
  assign lsum   = SUM_W'(len_lo_q) + SUM_W'(len_rdata);
  assign s8     = LIN_W'({cnt_q, 3'b000});
  assign low_p  = s8 <= LIN_W'(lsum);
  assign x1     = s8 - LIN_W'(lsum);
  assign x2     = LIN_W'({lsum_q, 1'b0}) + LIN_W'(lsum_q);
  assign add_sum = (CNT_W+1)'(cnt_rdata) + (CNT_W+1)'(amt_q);
  assign rnd    = (PROD_W+1)'(mul_p) + ((PROD_W+1)'(1) << 31);
  assign r      = rnd[PROD_W:32];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR:  if (clr_q[PAIR_W]) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          unique case (op_e'(s_axis_tuser_i))
            OP_ADD:   state_d = S_ADD_RD;
            OP_LEN:   state_d = S_LEN_WR;
            OP_QUERY: state_d = S_Q_RD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_RD: state_d = (match_q && a_q != b_q) ? S_ADD_WR : S_IDLE;
      S_ADD_WR: state_d = S_IDLE;
      S_LEN_WR: state_d = S_IDLE;
      S_Q_RD:   state_d = (a_q == b_q) ? S_OUT : S_Q_RD2;
      S_Q_RD2:  state_d = S_Q_EVAL;
      S_Q_EVAL: begin
        if (cnt_q == '0 || low_p || lsum == '0) state_d = S_OUT;
        else state_d = S_LOG_X;
      end
      S_LOG_X:     if (log_rsp.done) state_d = S_LOG_Y;
      S_LOG_Y:     if (log_rsp.done) state_d = S_SCALE_MUL;
      S_SCALE_MUL: state_d = S_SCALE_END;
      S_SCALE_END: state_d = S_OUT;
      S_OUT:       if (m_axis_tready_i) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready_o = (state_q == S_IDLE);
    m_axis_tvalid_o = (state_q == S_OUT);
    cnt_we    = 1'b0;
    cnt_waddr = {lo, hi};
    cnt_wdata = '0;
    cnt_raddr = {lo, hi};
    len_we    = (state_q == S_LEN_WR);
    len_raddr = (state_q == S_Q_RD2) ? hi : lo;
    log_req.start = 1'b0;
    log_req.value = x1;
    mul_a = log_mul_a;
    mul_b = log_mul_a;
    unique case (state_q)
      S_CLEAR: begin
        cnt_we    = !clr_q[PAIR_W];
        cnt_waddr = clr_q[PAIR_W-1:0];
      end
      S_ADD_WR: begin
        cnt_we    = 1'b1;
        cnt_wdata = add_sum[CNT_W] ? {CNT_W{1'b1}} : add_sum[CNT_W-1:0];
      end
      S_Q_EVAL: log_req.start = !(cnt_q == '0 || low_p || lsum == '0);
      S_LOG_X: begin
        log_req.start = log_rsp.done;
        log_req.value = x2;
      end
      S_SCALE_MUL: begin
        mul_a = mag_q;
        mul_b = LN_SCALE;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
    end
  end

  assign clr_d = (state_q == S_CLEAR && !clr_q[PAIR_W]) ? clr_q + 1'b1 : clr_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_q     <= s_axis_tdata_i[5:0];
      b_q     <= s_axis_tdata_i[11:6];
      match_q <= s_axis_tdata_i[12];
      amt_q   <= s_axis_tdata_i[44:13];
    end
    unique case (state_q)
      S_Q_RD: begin
        cnt_q    <= '0;
        status_q <= ST_SAME;
        dist_q   <= '0;
      end
      S_Q_RD2: begin
        cnt_q    <= cnt_rdata;
        len_lo_q <= len_rdata;
      end
      S_Q_EVAL: begin
        lsum_q <= lsum;
        dist_q <= '0;
        if (cnt_q == '0) begin
          status_q <= ST_NOSHARED;
        end else if (low_p) begin
          status_q <= ST_LOWP;
        end else begin
          status_q <= ST_VALID;
          if (lsum == '0) dist_q <= DIST_MIN;
        end
      end
      S_LOG_X: if (log_rsp.done) lx_q <= log_rsp.result;
      S_LOG_Y: begin
        if (log_rsp.done) begin
          pos_q <= lx_q >= log_rsp.result;
          mag_q <= MAN_W'((lx_q >= log_rsp.result) ? lx_q - log_rsp.result
                                                   : log_rsp.result - lx_q);
        end
      end
      S_SCALE_END: begin
        if (pos_q) begin
          dist_q <= (r >= MAN_W'(DIST_MAX) + 1'b1) ? DIST_MIN : DIST_W'(-r);
        end else begin
          dist_q <= (r >= MAN_W'(DIST_MAX)) ? DIST_MAX : r[DIST_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  pmjc_ram #(.WIDTH(CNT_W), .DEPTH(PAIRS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  pmjc_ram #(.WIDTH(LEN_W), .DEPTH(MAX_SEQS)) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (a_q),
    .wdata_i (amt_q),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  pmjc_log2 u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (log_req),
    .rsp_o   (log_rsp),
    .mul_a_o (log_mul_a),
    .mul_p_i (mul_p)
  );

  pmjc_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  assign m_axis_tuser_o = status_q;
  assign m_axis_tdata_o = {1'b0, cnt_q, dist_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready_o)
    else $error("Item taken during the clearing pass.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status_q != ST_VALID) |-> (dist_q == '0))
    else $error("Non-zero distance with an error status.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && status_q == ST_SAME) |-> (cnt_q == '0))
    else $error("Same-index query reports a shared count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("Stalled result beat changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_rsp.done |-> (state_q == S_LOG_X || state_q == S_LOG_Y))
    else $error("Logarithm finished outside a logarithm step.");
endmodule

// File: tb/sv/pairwise_match_jukes_cantor_test.sv
// Testbench for the pairwise match counter with Jukes-Cantor distance, self-checking.
`timescale 1ns / 100ps

module pairwise_match_jukes_cantor_test;
  import pmjc_pkg::*;

  typedef struct packed {
    logic [1:0]  status;
    logic [22:0] distance;
    logic [39:0] shared_count;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [47:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [63:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  pairwise_match_jukes_cantor i_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [39:0] match_count [0:63][0:63];
  logic [31:0] seq_len [0:63];
  bit          len_known [0:63];
  answer_t     pending_answers [$];
  int          failures = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  bit          hold_off = 1'b0;
  longint      cycle_count = 0;

  function automatic logic [29:0] log2_fixed(logic [63:0] n);
    int unsigned e;
    logic [63:0] m;
    logic [29:0] r;
    e = 0;
    for (int k = 63; k >= 0; k--) begin
      if (n[k]) begin
        e = k;
        break;
      end
    end
    m = (e >= 30) ? (n >> (e - 30)) : (n << (30 - e));
    r = '0;
    r[29:24] = e[5:0];
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic answer_t query_answer(logic [5:0] a, logic [5:0] b);
    answer_t ans;
    logic [5:0] lo, hi;
    logic [63:0] cnt, lsum, lx, ly, mag, r;
    longint d;
    bit pos;
    ans = '0;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (a == b) begin
      ans.status = ST_SAME;
      return ans;
    end
    cnt = match_count[lo][hi];
    lsum = 64'(seq_len[lo]) + 64'(seq_len[hi]);
    ans.shared_count = cnt[39:0];
    if (cnt == 0) ans.status = ST_NOSHARED;
    else if (8 * cnt <= lsum) ans.status = ST_LOWP;
    else if (lsum == 0) begin
      ans.status = ST_VALID;
      ans.distance = DIST_MIN;
    end else begin
      lx = 64'(log2_fixed(8 * cnt - lsum));
      ly = 64'(log2_fixed(3 * lsum));
      pos = lx >= ly;
      mag = pos ? lx - ly : ly - lx;
      r = (mag * 64'd8721810 + 64'h8000_0000) >> 32;
      if (r > 64'd4194304) r = 64'd4194304;
      d = pos ? -longint'(r) : longint'(r);
      if (d > 4194303) d = 4194303;
      if (d < -4194304) d = -4194304;
      ans.status = ST_VALID;
      ans.distance = d[22:0];
    end
    return ans;
  endfunction

  task automatic send_item(op_e op, logic [5:0] a, logic [5:0] b, logic m, logic [31:0] amt);
    logic [5:0] lo, hi;
    logic [40:0] s;
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid_i = 1'b1;
    s_axis_tuser_i  = op;
    s_axis_tdata_i  = {3'b0, amt, m, b, a};
    do @(posedge clk_i); while (!s_axis_tready_o);
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case (op)
      OP_ADD: begin
        if (m && a != b) begin
          s = 41'(match_count[lo][hi]) + 41'(amt);
          match_count[lo][hi] = s[40] ? 40'hFF_FFFF_FFFF : s[39:0];
        end
      end
      OP_LEN: begin
        seq_len[a] = amt;
        len_known[a] = 1'b1;
      end
      OP_QUERY: pending_answers.push_back(query_answer(a, b));
      default: ;
    endcase
    @(negedge clk_i);
    s_axis_tvalid_i = 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready_i <= !hold_off && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    answer_t got, want;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      got.status = m_axis_tuser_o;
      got.distance = m_axis_tdata_o[22:0];
      got.shared_count = m_axis_tdata_o[62:23];
      if (pending_answers.size() == 0) begin
        $error("unexpected result beat");
        failures++;
      end else begin
        want = pending_answers.pop_front();
        if (got.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, got.status);
          failures++;
        end
        if (got.distance !== want.distance) begin
          $error("distance: expected %0d, got %0d", $signed(want.distance),
                 $signed(got.distance));
          failures++;
        end
        if (got.shared_count !== want.shared_count) begin
          $error("shared_count: expected %0d, got %0d", want.shared_count,
                 got.shared_count);
          failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > 3_000_000) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic drain();
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  // Picks a random pair whose lengths are both known, so that no query reads an unset length.
  task automatic pick_pair(output logic [5:0] a, output logic [5:0] b, input int span);
    do a = 6'($urandom_range(span)); while (!len_known[a]);
    do b = 6'($urandom_range(span)); while (!len_known[b]);
  endtask

  task automatic test_directed();
    send_item(OP_QUERY, 6'd5, 6'd5, 1'b0, 32'd0);
    send_item(OP_LEN, 6'd0, 6'd0, 1'b0, 32'd0);
    send_item(OP_LEN, 6'd63, 6'd0, 1'b1, 32'd0);
    send_item(OP_QUERY, 6'd0, 6'd63, 1'b0, 32'd0);
    send_item(OP_ADD, 6'd63, 6'd0, 1'b1, 32'd1);
    send_item(OP_QUERY, 6'd0, 6'd63, 1'b0, 32'd0);
    send_item(OP_ADD, 6'd7, 6'd7, 1'b1, 32'd100);
    send_item(OP_ADD, 6'd1, 6'd2, 1'b0, 32'd100);
    send_item(OP_LEN, 6'd1, 6'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_LEN, 6'd2, 6'd0, 1'b0, 32'hFFFF_FFFF);
    send_item(OP_ADD, 6'd2, 6'd1, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 6'd1, 6'd2, 1'b0, 32'd0);
    for (int i = 0; i < 300; i++) send_item(OP_ADD, 6'd1, 6'd2, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_QUERY, 6'd2, 6'd1, 1'b0, 32'd0);
    send_item(OP_NONE, 6'd3, 6'd4, 1'b1, 32'd9);
    send_item(OP_LEN, 6'd3, 6'd0, 1'b0, 32'd100);
    send_item(OP_LEN, 6'd4, 6'd0, 1'b0, 32'd100);
    send_item(OP_ADD, 6'd3, 6'd4, 1'b1, 32'd26);
    send_item(OP_QUERY, 6'd3, 6'd4, 1'b0, 32'd0);
    send_item(OP_ADD, 6'd3, 6'd4, 1'b1, 32'd60);
    send_item(OP_QUERY, 6'd4, 6'd3, 1'b0, 32'd0);
    drain();
  endtask

  task automatic test_random(int count, int sidle, int ridle);
    logic [5:0] a, b;
    logic [31:0] amt;
    int span;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < count; i++) begin
      span = ($urandom_range(3) == 0) ? 63 : 7;
      amt = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(400));
      case ($urandom_range(9))
        0, 1: send_item(OP_LEN, 6'($urandom_range(span)), 6'($urandom()), 1'($urandom()), amt);
        2, 3: begin
          pick_pair(a, b, span);
          send_item(OP_QUERY, a, b, 1'($urandom()), $urandom());
        end
        4: send_item(OP_NONE, 6'($urandom()), 6'($urandom()), 1'($urandom()), $urandom());
        default: send_item(OP_ADD, 6'($urandom_range(span)), 6'($urandom_range(span)),
                           ($urandom_range(3) != 0), amt);
      endcase
    end
    drain();
  endtask

  task automatic test_backpressure();
    logic [5:0] a, b;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(negedge clk_i);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 8; i++) begin
        pick_pair(a, b, 7);
        send_item(OP_QUERY, a, b, 1'b0, 32'd0);
      end
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < 64; i++) begin
      len_known[i] = 1'b0;
      seq_len[i] = '0;
      for (int j = 0; j < 64; j++) match_count[i][j] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    for (int i = 5; i < 63; i += 9) send_item(OP_LEN, 6'(i), 6'd0, 1'b0, 32'($urandom_range(500)));
    test_random(470, 13, 83);
    test_backpressure();
    test_random(470, 83, 13);
    test_random(470, 0, 0);
    repeat (300) @(negedge clk_i);
    if (failures == 0 && pending_answers.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
